// ===== design/brb_pkg.sv =====
// shared constants, command codes and position arithmetic for the byte ring buffer
// depends on nothing; imported by byte_ring_buffer
`default_nettype none

package brb_pkg;

   localparam int SLOT_COUNT = 256;
   localparam int MAX_BURST  = 64;

   localparam int POS_W  = 8;
   localparam int DATA_W = 8;
   localparam int CMD_W  = 3;
   localparam int REM_W  = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;

   localparam logic [POS_W-1:0] USABLE_RESET = POS_W'(SLOT_COUNT - 1);
   localparam logic [POS_W:0]   USABLE_MAX   = (POS_W+1)'(SLOT_COUNT - 1);
   localparam logic [POS_W-1:0] BURST_CAP    = POS_W'(MAX_BURST);

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE   = 3'd0,
      CMD_ADVANCE = 3'd1,
      CMD_READ    = 3'd2,
      CMD_SKIP    = 3'd3,
      CMD_STATUS  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_BURST = 2'b10
   } state_type;

   // (pos + n) mod slots, valid while pos < slots and n < slots
   function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] pos,
                                                 input logic [POS_W-1:0] n,
                                                 input logic [POS_W:0]   slots);
      logic [POS_W:0] sum;
      sum = {1'b0, pos} + {1'b0, n};
      if (sum >= slots) begin
         sum = sum - slots;
      end
      return sum[POS_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/brb_ram.sv =====
// generic single-clock ram, one write port and one read port with registered read
// depends on nothing
`default_nettype none

module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/byte_ring_buffer.sv =====
// Byte ring buffer keeping one slot empty; usable size is set through the csr
// write channel (a write also empties the buffer). Write byte, advance, skip and
// status may be started back to back; their single result appears on rsp_strobe
// the cycle after start. A read burst of n bytes (n = min(count, bytes available,
// 64)) issues one byte store read per cycle; busy stays high while the reads after
// the first are issued, and the bytes come out on n consecutive strobes starting
// the cycle after start. Results cannot be held off: each is valid for exactly its
// strobe cycle. No clearing pass follows reset, and advance counts slots as filled
// without writing them, so the store can be read at slots that were never written.
// depends on brb_pkg and brb_ram
`default_nettype none

module byte_ring_buffer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // command channel
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [brb_pkg::CMD_W-1:0] req_cmd,
   input  wire logic [brb_pkg::DATA_W-1:0] req_data_in,
   input  wire logic [brb_pkg::POS_W-1:0] req_count,
   // result channel
   output logic                           rsp_strobe,
   output logic [brb_pkg::DATA_W-1:0]     rsp_data_out,
   output logic                           rsp_data_valid,
   output logic                           rsp_last,
   output logic [brb_pkg::POS_W-1:0]      rsp_done_count,
   output logic [brb_pkg::POS_W-1:0]      rsp_bytes_available,
   output logic [brb_pkg::POS_W-1:0]      rsp_free_space,
   output logic                           rsp_is_empty,
   // capacity register
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [brb_pkg::POS_W-1:0] csr_data
);

   import brb_pkg::*;

   state_type        state_ff, state_in;
   logic [POS_W-1:0] rd_pos_ff, rd_pos_in;
   logic [POS_W-1:0] wr_pos_ff, wr_pos_in;
   logic [POS_W-1:0] usable_ff, usable_in;
   logic [POS_W-1:0] burst_addr_ff, burst_addr_in;
   logic [REM_W-1:0] remain_ff, remain_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_data_valid_ff, rsp_data_valid_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [POS_W-1:0]  rsp_done_count_ff, rsp_done_count_in;
   logic [POS_W-1:0]  rsp_bytes_available_ff, rsp_bytes_available_in;
   logic [POS_W-1:0]  rsp_free_space_ff, rsp_free_space_in;
   logic              rsp_is_empty_ff, rsp_is_empty_in;

   logic              accept;
   logic              csr_write;
   logic [POS_W:0]    slots;
   logic [POS_W-1:0]  avail;
   logic [POS_W-1:0]  free_now;
   logic [POS_W-1:0]  n_adv;
   logic [POS_W-1:0]  n_av;
   logic [POS_W-1:0]  n_rd;
   logic [POS_W-1:0]  done;
   logic [POS_W-1:0]  avail_after;

   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [POS_W-1:0]  ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   brb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SLOT_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_pos_ff),
      .wr_data (req_data_in),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy      = (state_ff == ST_BURST);
   // a capacity write never shares an edge with an accepted command
   assign csr_ready = !busy && !start;
   assign accept    = start && !busy;
   assign csr_write = csr_valid && csr_ready;
   assign slots     = {1'b0, usable_ff} + (POS_W+1)'(1);

   // positions always stay below slots, so one conditional add wraps the difference
   always_comb begin
      logic [POS_W:0] diff;
      diff = {1'b0, wr_pos_ff} - {1'b0, rd_pos_ff};
      if (wr_pos_ff < rd_pos_ff) begin
         diff = diff + slots;
      end
      avail    = diff[POS_W-1:0];
      free_now = usable_ff - avail;
      n_adv    = (req_count < free_now) ? req_count : free_now;
      n_av     = (req_count < avail) ? req_count : avail;
      n_rd     = (n_av > BURST_CAP) ? BURST_CAP : n_av;
   end

   always_comb begin
      state_in               = state_ff;
      rd_pos_in              = rd_pos_ff;
      wr_pos_in              = wr_pos_ff;
      usable_in              = usable_ff;
      burst_addr_in          = burst_addr_ff;
      remain_in              = remain_ff;
      rsp_strobe_in          = 1'b0;
      rsp_data_valid_in      = 1'b0;
      rsp_last_in            = 1'b1;
      rsp_done_count_in      = rsp_done_count_ff;
      rsp_bytes_available_in = rsp_bytes_available_ff;
      rsp_free_space_in      = rsp_free_space_ff;
      rsp_is_empty_in        = rsp_is_empty_ff;
      ram_wr_en              = 1'b0;
      ram_rd_en              = 1'b0;
      ram_rd_addr            = rd_pos_ff;
      done                   = '0;
      avail_after            = avail;

      if (csr_write) begin
         if (csr_data == '0) begin
            usable_in = POS_W'(1);
         end else if ({1'b0, csr_data} > USABLE_MAX) begin
            usable_in = USABLE_MAX[POS_W-1:0];
         end else begin
            usable_in = csr_data;
         end
         rd_pos_in = '0;
         wr_pos_in = '0;
      end else if (state_ff == ST_BURST) begin
         // one store read per cycle; the strobe lines up with the registered read data
         ram_rd_en         = 1'b1;
         ram_rd_addr       = burst_addr_ff;
         burst_addr_in     = wrap_add(burst_addr_ff, POS_W'(1), slots);
         remain_in         = remain_ff - REM_W'(1);
         rsp_strobe_in     = 1'b1;
         rsp_data_valid_in = 1'b1;
         rsp_last_in       = (remain_ff == REM_W'(1));
         if (remain_ff == REM_W'(1)) begin
            state_in = ST_IDLE;
         end
      end else if (accept) begin
         rsp_strobe_in = 1'b1;
         case (req_cmd)
            CMD_WRITE: begin
               if (free_now != '0) begin
                  ram_wr_en   = 1'b1;
                  wr_pos_in   = wrap_add(wr_pos_ff, POS_W'(1), slots);
                  done        = POS_W'(1);
                  avail_after = avail + POS_W'(1);
               end
            end
            CMD_ADVANCE: begin
               wr_pos_in   = wrap_add(wr_pos_ff, n_adv, slots);
               done        = n_adv;
               avail_after = avail + n_adv;
            end
            CMD_READ: begin
               done        = n_rd;
               avail_after = avail - n_rd;
               if (n_rd != '0) begin
                  ram_rd_en         = 1'b1;
                  rsp_data_valid_in = 1'b1;
                  rsp_last_in       = (n_rd == POS_W'(1));
                  rd_pos_in         = wrap_add(rd_pos_ff, n_rd, slots);
                  burst_addr_in     = wrap_add(rd_pos_ff, POS_W'(1), slots);
                  remain_in         = REM_W'(n_rd - POS_W'(1));
                  if (n_rd != POS_W'(1)) begin
                     state_in = ST_BURST;
                  end
               end
            end
            CMD_SKIP: begin
               rd_pos_in   = wrap_add(rd_pos_ff, n_av, slots);
               done        = n_av;
               avail_after = avail - n_av;
            end
            default: begin
               // status and unused codes change nothing
               done = '0;
            end
         endcase
         rsp_done_count_in      = done;
         rsp_bytes_available_in = avail_after;
         rsp_free_space_in      = usable_ff - avail_after;
         rsp_is_empty_in        = (avail_after == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_pos_ff     <= '0;
         wr_pos_ff     <= '0;
         usable_ff     <= USABLE_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pos_ff     <= rd_pos_in;
         wr_pos_ff     <= wr_pos_in;
         usable_ff     <= usable_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_addr_ff          <= burst_addr_in;
      remain_ff              <= remain_in;
      rsp_data_valid_ff      <= rsp_data_valid_in;
      rsp_last_ff            <= rsp_last_in;
      rsp_done_count_ff      <= rsp_done_count_in;
      rsp_bytes_available_ff <= rsp_bytes_available_in;
      rsp_free_space_ff      <= rsp_free_space_in;
      rsp_is_empty_ff        <= rsp_is_empty_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_data_out        = rsp_data_valid_ff ? ram_rd_data : '0;
   assign rsp_data_valid      = rsp_data_valid_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_done_count      = rsp_done_count_ff;
   assign rsp_bytes_available = rsp_bytes_available_ff;
   assign rsp_free_space      = rsp_free_space_ff;
   assign rsp_is_empty        = rsp_is_empty_ff;

   // every burst cycle must put a byte transaction out on the next cycle
   a_burst_emits: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_strobe && rsp_data_valid))
      else $error("burst cycle produced no byte transaction");

   // a byte that is not the last of its burst means the burst is still running
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data_valid && !rsp_last) |-> busy)
      else $error("burst stopped before its last byte");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data_valid) |-> rsp_last)
      else $error("non-byte transaction without last");

   a_space_sums: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         (({1'b0, rsp_bytes_available} + {1'b0, rsp_free_space}) == {1'b0, usable_ff}))
      else $error("available plus free does not match usable size");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_empty == (rsp_bytes_available == '0)))
      else $error("empty flag disagrees with byte count");

endmodule

`default_nettype wire
